[rtl/core/bdrxa_pkg.sv]
// Shared types and constants for the blocked dual-row XOR accumulator.
package bdrxa_pkg;

	// Accumulator geometry
	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int COLCFG_W    = 11;
	localparam int ROW_W       = 16;
	localparam int BLK_W       = 16;
	localparam int WORD_W      = 32;

	// Result queue
	localparam int OUT_DEPTH = 3;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// APB register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_COLUMN_COUNT   = 2'd0,
		REG_ROWS_PER_BLOCK = 2'd1,
		REG_BLOCK_COUNT    = 2'd2
	} reg_idx_t;

	// One result beat
	typedef struct packed {
		logic [WORD_W-1:0] sum_one;
		logic [WORD_W-1:0] sum_two;
		logic [COL_W-1:0]  column_index;
		logic [BLK_W-1:0]  block_index;
		logic              matrix_done;
	} result_t;

endpackage

[rtl/core/bdrxa_out_fifo.sv]
// Three-entry result queue between the accumulator pipeline and the output port.
module bdrxa_out_fifo
	import bdrxa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  result_t              push_data,
	input  logic                 pop,
	output logic                 nonempty,
	output result_t              head,
	output logic [OUT_CNT_W-1:0] count
);

	result_t              entry_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;

	// Pointer wrap at the queue depth
	function automatic logic [OUT_PTR_W-1:0] ptr_next(input logic [OUT_PTR_W-1:0] p);
		logic [OUT_PTR_W-1:0] n;
		n = (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	// Storage, no reset on payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];
	assign count    = count_q;

endmodule

[rtl/core/blocked_dual_row_xor_accumulate.sv]
// Top level: blocked two-query XOR accumulator over a streamed GF(2) matrix.
//
// Input channel (in_valid / in_stall): one 32-bit matrix word per beat in row-major
// order, with its row's two query bits and a first_word flag that restarts the
// column, row and block counters. Output channel (out_valid / out_stall): one beat
// per word of the last row of each block, carrying both column sums, the column and
// block index, and matrix_done on the last column of the last block.
// Words past the configured number of blocks are absorbed without a result.
// Configuration goes through the APB port: column_count at 0x0, rows_per_block at
// 0x4, block_count at 0x8; write only while the block is idle.
// Throughput is one word per cycle while in_stall is low. The accumulators sit in one
// 1024 x 64 RAM with a registered read; each word within the configured blocks does
// one read-modify-write, with the previous write forwarded when consecutive words
// hit the same column. Each result goes through stage 1 and the result queue.
// Reset: all 1024 RAM addresses are swept to zero; in_stall stays high meanwhile.
// When the receiver stalls, up to three results queue; in_stall is high while the
// queued results plus the word in stage 1 reach three, and drops once that sum falls
// below three again.
module blocked_dual_row_xor_accumulate
	import bdrxa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	// Input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [WORD_W-1:0]   matrix_word,
	input  logic                select_one,
	input  logic                select_two,
	input  logic                first_word,
	// Output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WORD_W-1:0]   sum_one,
	output logic [WORD_W-1:0]   sum_two,
	output logic [COL_W-1:0]    column_index,
	output logic [BLK_W-1:0]    block_index,
	output logic                matrix_done
);

	// Configuration registers
	logic [COLCFG_W-1:0] column_count_q;
	logic [ROW_W-1:0]    rows_per_block_q;
	logic [BLK_W-1:0]    block_count_q;

	// Stream counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [BLK_W-1:0] blk_q;

	// Clearing sweep
	logic             clearing_q;
	logic [COL_W-1:0] clr_addr_q;

	// Accumulator RAM: [63:32] query two, [31:0] query one
	logic [2*WORD_W-1:0] acc_mem [MAX_COLUMNS];
	logic [2*WORD_W-1:0] rd_s1;

	// Stage 1 item
	logic              valid_s1;
	logic              act_s1;
	logic              fresh_s1;
	logic              emit_s1;
	logic              done_s1;
	logic              sel1_s1;
	logic              sel2_s1;
	logic [WORD_W-1:0] word_s1;
	logic [COL_W-1:0]  col_s1;
	logic [BLK_W-1:0]  blk_s1;

	// Write forwarding
	logic                fwd_vld_q;
	logic [COL_W-1:0]    fwd_addr_q;
	logic [2*WORD_W-1:0] fwd_data_q;

	logic                 accept;
	logic                 cfg_wr;
	logic [COLCFG_W-1:0]  cols_eff;
	logic [ROW_W-1:0]     rpb_eff;
	logic [COL_W-1:0]     col0;
	logic [ROW_W-1:0]     row0;
	logic [BLK_W-1:0]     blk0;
	logic [COL_W-1:0]     c0;
	logic                 active0;
	logic                 fresh0;
	logic                 last_row0;
	logic                 last_col0;
	logic                 done0;
	logic [2*WORD_W-1:0]  base_s1;
	logic [WORD_W-1:0]    new1_s1;
	logic [WORD_W-1:0]    new2_s1;
	logic                 we_s1;
	logic                 mem_we;
	logic [COL_W-1:0]     mem_waddr;
	logic [2*WORD_W-1:0]  mem_wdata;
	logic                 fifo_nonempty;
	logic [OUT_CNT_W-1:0] fifo_count;
	logic                 fifo_pop;
	result_t              res_push;
	result_t              res_head;

	// APB write and read-back
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q   <= COLCFG_W'(1);
			rows_per_block_q <= ROW_W'(1);
			block_count_q    <= BLK_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_COLUMN_COUNT:   column_count_q   <= pwdata[COLCFG_W-1:0];
				REG_ROWS_PER_BLOCK: rows_per_block_q <= pwdata[ROW_W-1:0];
				REG_BLOCK_COUNT:    block_count_q    <= pwdata[BLK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COLUMN_COUNT:   prdata = PDATA_W'(column_count_q);
			REG_ROWS_PER_BLOCK: prdata = PDATA_W'(rows_per_block_q);
			REG_BLOCK_COUNT:    prdata = PDATA_W'(block_count_q);
			default:            prdata = '0;
		endcase
	end

	// Effective row length and block height
	always_comb begin
		if (column_count_q == '0) begin
			cols_eff = COLCFG_W'(1);
		end else if (column_count_q > COLCFG_W'(MAX_COLUMNS)) begin
			cols_eff = COLCFG_W'(MAX_COLUMNS);
		end else begin
			cols_eff = column_count_q;
		end
		rpb_eff = (rows_per_block_q == '0) ? ROW_W'(1) : rows_per_block_q;
	end

	// Input handshake: room for this result and the one in stage 1
	assign in_stall = clearing_q
		|| ((OUT_CNT_W + 1)'(fifo_count) + (OUT_CNT_W + 1)'(valid_s1)
		>= (OUT_CNT_W + 1)'(OUT_DEPTH));
	assign accept = in_valid && !in_stall;

	// Stage 0: position of this word
	always_comb begin
		col0      = first_word ? '0 : col_q;
		row0      = first_word ? '0 : row_q;
		blk0      = first_word ? '0 : blk_q;
		active0   = (blk0 < block_count_q);
		c0        = ({1'b0, col0} >= cols_eff) ? '0 : col0;
		fresh0    = (row0 == '0);
		last_col0 = (({1'b0, c0} + 1'b1) >= cols_eff);
		last_row0 = (({1'b0, row0} + 1'b1) >= {1'b0, rpb_eff});
		done0     = last_col0 && (({1'b0, blk0} + 1'b1) >= {1'b0, block_count_q});
	end

	// Counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			blk_q <= '0;
		end else if (accept) begin
			if (!active0) begin
				col_q <= col0;
				row_q <= row0;
				blk_q <= blk0;
			end else if (last_col0) begin
				col_q <= '0;
				if (last_row0) begin
					row_q <= '0;
					blk_q <= (blk0 != '1) ? blk0 + 1'b1 : blk0;
				end else begin
					row_q <= row0 + 1'b1;
					blk_q <= blk0;
				end
			end else begin
				col_q <= c0 + 1'b1;
				row_q <= row0;
				blk_q <= blk0;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= active0;
			fresh_s1 <= fresh0;
			emit_s1  <= last_row0;
			done_s1  <= done0;
			sel1_s1  <= select_one;
			sel2_s1  <= select_two;
			word_s1  <= matrix_word;
			col_s1   <= c0;
			blk_s1   <= blk0;
		end
	end

	// Read-modify-write of the column's two sums
	assign base_s1 = fresh_s1 ? '0
		: ((fwd_vld_q && (fwd_addr_q == col_s1)) ? fwd_data_q : rd_s1);
	assign new1_s1 = base_s1[WORD_W-1:0] ^ (sel1_s1 ? word_s1 : '0);
	assign new2_s1 = base_s1[2*WORD_W-1:WORD_W] ^ (sel2_s1 ? word_s1 : '0);
	assign we_s1   = valid_s1 && act_s1;

	// RAM write port shared with the clearing sweep
	assign mem_we    = clearing_q || we_s1;
	assign mem_waddr = clearing_q ? clr_addr_q : col_s1;
	assign mem_wdata = clearing_q ? '0 : {new2_s1, new1_s1};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			acc_mem[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= acc_mem[c0];
	end

	// Forward the write that lands on the same edge as the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= we_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_s1) begin
			fwd_addr_q <= col_s1;
			fwd_data_q <= {new2_s1, new1_s1};
		end
	end

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == COL_W'(MAX_COLUMNS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Result queue
	always_comb begin
		res_push.sum_one      = new1_s1;
		res_push.sum_two      = new2_s1;
		res_push.column_index = col_s1;
		res_push.block_index  = blk_s1;
		res_push.matrix_done  = done_s1;
	end

	assign fifo_pop = fifo_nonempty && !out_stall;

	bdrxa_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (we_s1 && emit_s1),
		.push_data (res_push),
		.pop       (fifo_pop),
		.nonempty  (fifo_nonempty),
		.head      (res_head),
		.count     (fifo_count)
	);

	assign out_valid    = fifo_nonempty;
	assign sum_one      = res_head.sum_one;
	assign sum_two      = res_head.sum_two;
	assign column_index = res_head.column_index;
	assign block_index  = res_head.block_index;
	assign matrix_done  = res_head.matrix_done;

endmodule

[rtl/core/bdrxa_checker.sv]
// Port-level checks for the blocked dual-row XOR accumulator, bound to the top level.
module bdrxa_checker
	import bdrxa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] sum_one,
	input logic [WORD_W-1:0] sum_two,
	input logic [COL_W-1:0]  column_index,
	input logic [BLK_W-1:0]  block_index,
	input logic              matrix_done
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_one) && $stable(sum_two)
		&& $stable(column_index) && $stable(block_index) && $stable(matrix_done))
		else $error("result beat changed while stalled");

	// A result only shows up after an accepted word beat
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching input beat");

	// The accumulator sweep holds off input right after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input accepted during the accumulator sweep");

endmodule

bind blocked_dual_row_xor_accumulate bdrxa_checker u_bdrxa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sum_one      (sum_one),
	.sum_two      (sum_two),
	.column_index (column_index),
	.block_index  (block_index),
	.matrix_done  (matrix_done)
);

[sim/blocked_dual_row_xor_accumulate_test.sv]
// Self-checking testbench for the blocked dual-row XOR accumulator.
module blocked_dual_row_xor_accumulate_test;
	import bdrxa_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 8;

	// One matrix word waiting to be sent
	typedef struct {
		logic [WORD_W-1:0] word;
		logic              sel_one;
		logic              sel_two;
		logic              restart;
	} matrix_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [WORD_W-1:0]  matrix_word = '0;
	logic               select_one = 1'b0;
	logic               select_two = 1'b0;
	logic               first_word = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [WORD_W-1:0]  sum_one;
	logic [WORD_W-1:0]  sum_two;
	logic [COL_W-1:0]   column_index;
	logic [BLK_W-1:0]   block_index;
	logic               matrix_done;

	// Register mirror
	logic [COLCFG_W-1:0] cfg_columns;
	logic [ROW_W-1:0]    cfg_rows;
	logic [BLK_W-1:0]    cfg_blocks;

	// Predicted accumulator state
	logic [WORD_W-1:0] acc_one [MAX_COLUMNS];
	logic [WORD_W-1:0] acc_two [MAX_COLUMNS];
	logic [COL_W-1:0]  col_pos;
	logic [ROW_W-1:0]  row_pos;
	logic [BLK_W-1:0]  blk_pos;

	matrix_beat_t pending_words[$];
	result_t      sums_due[$];
	matrix_beat_t next_beat;

	int unsigned in_gap = 0;
	int unsigned stall_left = 0;
	int unsigned in_idle_pct = 0;
	int unsigned out_idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	blocked_dual_row_xor_accumulate i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.matrix_word  (matrix_word),
		.select_one   (select_one),
		.select_two   (select_two),
		.first_word   (first_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sum_one      (sum_one),
		.sum_two      (sum_two),
		.column_index (column_index),
		.block_index  (block_index),
		.matrix_done  (matrix_done)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Effective row length: zero acts as one, oversize clamps to the RAM depth
	function automatic int unsigned eff_cols();
		if (cfg_columns == '0) return 1;
		if (cfg_columns > MAX_COLUMNS) return MAX_COLUMNS;
		return 32'(cfg_columns);
	endfunction

	function automatic int unsigned eff_rows();
		return (cfg_rows == '0) ? 1 : 32'(cfg_rows);
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap(int unsigned pct);
		if ($urandom_range(0, 99) >= pct) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// Fold one accepted word into the column sums; queue the block result it finishes
	function automatic void fold_word(logic [WORD_W-1:0] word, logic sel_one, logic sel_two,
			logic restart);
		int unsigned cols;
		int unsigned rows;
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] v2;
		logic fresh;
		logic last_row;
		logic last_col;
		result_t res;
		cols = eff_cols();
		rows = eff_rows();
		if (restart) begin
			col_pos = '0;
			row_pos = '0;
			blk_pos = '0;
		end
		// past the last block everything is absorbed
		if (blk_pos >= cfg_blocks) return;
		// row length shrunk under a running matrix
		if (col_pos >= cols) col_pos = '0;
		fresh = (row_pos == '0);
		last_row = (row_pos + 1 >= rows);
		last_col = (col_pos + 1 >= cols);
		// first row of a block overwrites instead of XORing
		v1 = fresh ? '0 : acc_one[col_pos];
		v2 = fresh ? '0 : acc_two[col_pos];
		if (sel_one) v1 ^= word;
		if (sel_two) v2 ^= word;
		acc_one[col_pos] = v1;
		acc_two[col_pos] = v2;
		if (last_row) begin
			res.sum_one = v1;
			res.sum_two = v2;
			res.column_index = col_pos;
			res.block_index = blk_pos;
			res.matrix_done = last_col && (blk_pos + 1 >= cfg_blocks);
			sums_due.push_back(res);
		end
		if (last_col) begin
			col_pos = '0;
			if (last_row) begin
				row_pos = '0;
				if (blk_pos != '1) blk_pos++;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endfunction

	function automatic void push_beat(logic [WORD_W-1:0] word, logic sel_one, logic sel_two,
			logic restart);
		matrix_beat_t b;
		b.word = word;
		b.sel_one = sel_one;
		b.sel_two = sel_two;
		b.restart = restart;
		pending_words.push_back(b);
	endfunction

	// Queue whole matrices with random content for the current registers. A few are
	// cut short, a few words carry stray query bits. Without fresh_start the first
	// matrix continues where the block left off.
	function automatic void queue_matrices(int unsigned budget, bit fresh_start);
		int unsigned cols;
		int unsigned blocks;
		int unsigned words;
		int unsigned sent;
		int unsigned k;
		logic sel_one;
		logic sel_two;
		logic [WORD_W-1:0] word;
		bit restart;
		cols = eff_cols();
		blocks = (cfg_blocks == '0) ? 1 : 32'(cfg_blocks);
		sent = 0;
		restart = fresh_start;
		sel_one = 1'b0;
		sel_two = 1'b0;
		while (sent < budget) begin
			words = cols * (eff_rows() * blocks + $urandom_range(0, 2));
			if ($urandom_range(0, 9) == 0) words = $urandom_range(1, words);
			for (k = 0; k < words && sent < budget; k++) begin
				if (k % cols == 0) begin
					sel_one = 1'($urandom_range(0, 1));
					sel_two = 1'($urandom_range(0, 1));
				end
				case ($urandom_range(0, 9))
					0: word = '0;
					1: word = '1;
					default: word = $urandom;
				endcase
				if ($urandom_range(0, 31) == 0)
					push_beat(word, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						restart && k == 0);
				else
					push_beat(word, sel_one, sel_two, restart && k == 0);
				sent++;
			end
			restart = 1'b1;
		end
	endfunction

	// Input driver: presents queued beats and folds each accepted one into the prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				fold_word(matrix_word, select_one, select_two, first_word);
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					next_beat = pending_words.pop_front();
					in_valid <= 1'b1;
					matrix_word <= next_beat.word;
					select_one <= next_beat.sel_one;
					select_two <= next_beat.sel_two;
					first_word <= next_beat.restart;
					in_gap = pick_gap(in_idle_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left--;
			end else begin
				stall_left = pick_gap(out_idle_pct);
				out_stall <= (stall_left != 0);
			end
		end
	end

	// Result monitor: every accepted beat against the oldest predicted sum
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sums_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: sum_one=%h sum_two=%h ", sum_one, sum_two,
						"column=%0d block=%0d done=%0b",
						column_index, block_index, matrix_done);
				mismatches++;
			end else begin
				if (sum_one !== sums_due[0].sum_one || sum_two !== sums_due[0].sum_two ||
						column_index !== sums_due[0].column_index ||
						block_index !== sums_due[0].block_index ||
						matrix_done !== sums_due[0].matrix_done) begin
					if (mismatches < 10)
						$display("mismatch at cycle %0d: ", cycle_count,
							"expected %h %h col %0d blk %0d done %0b, ",
							sums_due[0].sum_one, sums_due[0].sum_two,
							sums_due[0].column_index, sums_due[0].block_index,
							sums_due[0].matrix_done,
							"got %h %h col %0d blk %0d done %0b",
							sum_one, sum_two, column_index, block_index, matrix_done);
					mismatches++;
				end
				void'(sums_due.pop_front());
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL blocked_dual_row_xor_accumulate");
			$finish;
		end
	end

	// Setup cycle then access cycle; the register takes the value at the end of the access cycle
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COLUMN_COUNT:   cfg_columns = value[COLCFG_W-1:0];
			REG_ROWS_PER_BLOCK: cfg_rows = value[ROW_W-1:0];
			REG_BLOCK_COUNT:    cfg_blocks = value[BLK_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input int unsigned cols, input int unsigned rows,
			input int unsigned blocks);
		reg_write(REG_COLUMN_COUNT, cols);
		reg_write(REG_ROWS_PER_BLOCK, rows);
		reg_write(REG_BLOCK_COUNT, blocks);
	endtask

	// Wait until everything sent has been accepted and answered, then let the pipe drain
	task automatic settle();
		while (pending_words.size() != 0 || in_valid || sums_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic pick_idling();
		case ($urandom_range(0, 3))
			0: in_idle_pct = 0;
			1: in_idle_pct = 15;
			default: in_idle_pct = 40;
		endcase
		case ($urandom_range(0, 3))
			0: out_idle_pct = 0;
			1: out_idle_pct = 15;
			default: out_idle_pct = 40;
		endcase
	endtask

	initial begin
		int unsigned ph;
		cfg_columns = 1;
		cfg_rows = 1;
		cfg_blocks = 1;
		col_pos = '0;
		row_pos = '0;
		blk_pos = '0;
		foreach (acc_one[i]) begin
			acc_one[i] = '0;
			acc_two[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: one column, one row, one block; second word lands past the end
		in_idle_pct = 30;
		out_idle_pct = 30;
		push_beat(32'hC3C3_3C3C, 1'b1, 1'b1, 1'b0);
		push_beat(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		settle();

		// Directed: 3 columns, 2 rows per block, 2 blocks
		set_config(3, 2, 2);
		push_beat(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
		push_beat(32'h1234_5678, 1'b1, 1'b0, 1'b0);
		push_beat(32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0);
		push_beat(32'h5555_5555, 1'b0, 1'b1, 1'b0);
		push_beat(32'h0000_0000, 1'b0, 1'b1, 1'b0);
		push_beat(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
		push_beat(32'h8000_0000, 1'b1, 1'b1, 1'b0);
		push_beat(32'h0000_0001, 1'b1, 1'b1, 1'b0);
		push_beat(32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0);
		push_beat(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
		// query bits that differ inside one row
		push_beat(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
		push_beat(32'h0F0F_0F0F, 1'b0, 1'b0, 1'b0);
		// past the last block: absorbed
		push_beat(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		push_beat(32'h0000_0000, 1'b0, 1'b0, 1'b0);
		// restart: block start overwrites stale sums
		push_beat(32'h0123_4567, 1'b1, 1'b1, 1'b1);
		push_beat(32'h89AB_CDEF, 1'b1, 1'b1, 1'b0);
		push_beat(32'hF0F0_F0F0, 1'b1, 1'b1, 1'b0);
		push_beat(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		push_beat(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		push_beat(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
		settle();

		// One-word rows, one row per block, many blocks
		pick_idling();
		set_config(1, 1, 65535);
		queue_matrices(100, 1'b1);
		settle();

		// Longest blocks, then the block length cut under a running matrix
		pick_idling();
		set_config(7, 65535, 2);
		queue_matrices(70, 1'b1);
		settle();
		reg_write(REG_ROWS_PER_BLOCK, 3);
		queue_matrices(56, 1'b0);
		settle();

		// Oversize row length clamps to the RAM depth, then the row length cut under
		// a running matrix
		pick_idling();
		set_config(2047, 1, 3);
		queue_matrices(350, 1'b1);
		settle();
		reg_write(REG_COLUMN_COUNT, 5);
		queue_matrices(40, 1'b0);
		settle();

		// All zero registers: zero blocks absorbs everything
		pick_idling();
		set_config(0, 0, 0);
		queue_matrices(20, 1'b1);
		settle();

		// Zero row length and block length with blocks to fill
		set_config(0, 0, 4);
		queue_matrices(30, 1'b1);
		settle();

		// Random small geometries
		for (ph = 0; ph < 6; ph++) begin
			pick_idling();
			set_config(($urandom_range(0, 3) == 0) ? $urandom_range(17, 64)
				: $urandom_range(1, 16), $urandom_range(1, 6), $urandom_range(1, 5));
			queue_matrices(45, 1'b1);
			settle();
		end

		if (mismatches == 0)
			$display("PASS blocked_dual_row_xor_accumulate");
		else
			$display("FAIL blocked_dual_row_xor_accumulate");
		$finish;
	end

endmodule
